// ===== src/frame_rate_estimator_throttle_core_macros.svh =====
// Assertion helpers shared by the frame rate throttle RTL.
`ifndef FRAME_RATE_ESTIMATOR_THROTTLE_CORE_MACROS_SVH
`define FRAME_RATE_ESTIMATOR_THROTTLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRET_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fret assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FRET_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fret assertion failed");

`endif

// ===== src/fret_pkg.sv =====
package fret_pkg;

    localparam int DEF_STAMP_BITS = 48;
    localparam int DEF_WAIT_BITS  = 32;
    localparam int DEF_FRAC_BITS  = 16;

    // The integer part of a rate holds up to 1000 frames per second.
    localparam int RATE_INT_BITS  = 10;
    // Headroom of the blend sum over the rate width (sum < 128 * 2^RATE_BITS).
    localparam int SUM_GUARD_BITS = 7;
    localparam int TARGET_BITS    = 26;

    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam int REG_IDX_BIT    = 2;

    localparam int MS_PER_SEC       = 1000;
    localparam int BLEND_OLD        = 97;
    localparam int BLEND_NEW        = 3;
    localparam int BLEND_DEN        = 100;
    localparam int BLEND_ROUND      = 50;
    localparam int TARGET_RESET_FPS = 60;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef enum logic {
        REG_TARGET_RATE    = 1'b0,
        REG_UNLIMITED_MODE = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INTERVAL,
        ST_RATE_START,
        ST_DIV_RATE,
        ST_BLEND_OLD,
        ST_BLEND_NEW,
        ST_AVG_START,
        ST_DIV_AVG,
        ST_EMIT
    } t_state;

endpackage

// ===== src/fret_ifs.sv =====
interface fret_in_if #(
    parameter int STAMP_BITS = fret_pkg::DEF_STAMP_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [STAMP_BITS-1:0] timestamp_ms;

    modport source (output valid, output action, output timestamp_ms, input ready);
    modport sink   (input valid, input action, input timestamp_ms, output ready);
endinterface

interface fret_out_if #(
    parameter int WAIT_BITS = fret_pkg::DEF_WAIT_BITS,
    parameter int RATE_BITS = fret_pkg::DEF_FRAC_BITS + fret_pkg::RATE_INT_BITS
);
    logic                 valid;
    logic                 ready;
    logic [WAIT_BITS-1:0] wait_amount;
    logic [RATE_BITS-1:0] rate_estimate;

    modport source (output valid, output wait_amount, output rate_estimate, input ready);
    modport sink   (input valid, input wait_amount, input rate_estimate, output ready);
endinterface

// ===== src/frame_rate_estimator_throttle_core.sv =====
// Frame rate estimator and throttle. Each input transaction is either a frame
// tick carrying a millisecond timestamp or a wait query; each one produces
// exactly one result transaction with the wait count and the smoothed rate in
// unsigned fixed point with FRAC_BITS fraction bits. Items are handled one at
// a time. A query, or the first tick after reset, goes from idle straight to
// the emit state. Any later tick passes through the interval, rate division,
// blend and average division states, using a shared bit-serial divider that
// runs twice, once for 1000/interval and once for the divide by 100 of the
// 0.97/0.03 blend. A tick whose interval is 2^RATE_BITS ms or more gives a
// rate of zero and skips the first division. The output register holds a
// finished result so the next item can be accepted while it waits to be
// taken. The target rate (address 0) and unlimited mode (address 4) are
// written over the APB port; the user must write them only while the block
// is idle, which the block itself does not enforce.
module frame_rate_estimator_throttle_core #(
    parameter int STAMP_BITS = fret_pkg::DEF_STAMP_BITS,
    parameter int WAIT_BITS  = fret_pkg::DEF_WAIT_BITS,
    parameter int FRAC_BITS  = fret_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fret_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [fret_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [fret_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    fret_in_if.sink                            i_in,
    fret_out_if.source                         o_out
);

    localparam int RATE_BITS = FRAC_BITS + fret_pkg::RATE_INT_BITS;
    localparam int SUM_BITS  = RATE_BITS + fret_pkg::SUM_GUARD_BITS;

    logic [fret_pkg::TARGET_BITS-1:0] target;
    logic                             unlimited;
    logic                             div_start;
    logic [SUM_BITS-1:0]              div_num;
    logic [RATE_BITS-1:0]             div_den;
    logic                             div_done;
    logic [SUM_BITS-1:0]              div_quot;
    logic                             emit_valid;
    logic                             emit_ready;
    logic [WAIT_BITS-1:0]             emit_wait;
    logic [RATE_BITS-1:0]             emit_rate;

    logic                             r_out_valid;
    logic [WAIT_BITS-1:0]             r_out_wait;
    logic [RATE_BITS-1:0]             r_out_rate;

    fret_apb_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_target    (target),
        .o_unlimited (unlimited)
    );

    fret_serial_div #(
        .NUM_BITS (SUM_BITS),
        .DEN_BITS (RATE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    fret_ctrl #(
        .STAMP_BITS (STAMP_BITS),
        .WAIT_BITS  (WAIT_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .RATE_BITS  (RATE_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_target     (target),
        .i_unlimited  (unlimited),
        .o_div_start  (div_start),
        .o_div_num    (div_num),
        .o_div_den    (div_den),
        .i_div_done   (div_done),
        .i_div_quot   (div_quot),
        .o_emit_valid (emit_valid),
        .o_emit_wait  (emit_wait),
        .o_emit_rate  (emit_rate),
        .i_emit_ready (emit_ready)
    );

    // The output register takes a new result when it is empty or being drained.
    assign emit_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_valid && emit_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_valid && emit_ready) begin
            r_out_wait <= emit_wait;
            r_out_rate <= emit_rate;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.wait_amount   = r_out_wait;
    assign o_out.rate_estimate = r_out_rate;

endmodule

// ===== src/fret_apb_regs.sv =====
module fret_apb_regs #(
    parameter int FRAC_BITS = fret_pkg::DEF_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fret_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [fret_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [fret_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready,
    output logic [fret_pkg::TARGET_BITS-1:0]      o_target,
    output logic                                  o_unlimited
);

    localparam logic [fret_pkg::TARGET_BITS-1:0] TARGET_RESET =
        fret_pkg::TARGET_BITS'(64'(fret_pkg::TARGET_RESET_FPS) << FRAC_BITS);

    logic [fret_pkg::TARGET_BITS-1:0] r_target;
    logic                             r_unlimited;
    fret_pkg::t_reg_idx               reg_idx;
    logic                             wr_en;

    assign reg_idx = fret_pkg::t_reg_idx'(paddr[fret_pkg::REG_IDX_BIT]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= TARGET_RESET;
            r_unlimited <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                fret_pkg::REG_TARGET_RATE: begin
                    r_target <= pwdata[fret_pkg::TARGET_BITS-1:0];
                end
                fret_pkg::REG_UNLIMITED_MODE: begin
                    r_unlimited <= pwdata[0];
                end
                default: begin
                    r_target <= r_target;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fret_pkg::REG_TARGET_RATE: begin
                prdata = fret_pkg::APB_DATA_BITS'(r_target);
            end
            fret_pkg::REG_UNLIMITED_MODE: begin
                prdata = fret_pkg::APB_DATA_BITS'(r_unlimited);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_target    = r_target;
    assign o_unlimited = r_unlimited;

endmodule

// ===== src/fret_serial_div.sv =====
`include "frame_rate_estimator_throttle_core_macros.svh"

module fret_serial_div #(
    parameter int NUM_BITS = fret_pkg::DEF_FRAC_BITS + fret_pkg::RATE_INT_BITS
                             + fret_pkg::SUM_GUARD_BITS,
    parameter int DEN_BITS = fret_pkg::DEF_FRAC_BITS + fret_pkg::RATE_INT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [CNT_BITS-1:0] r_count;
    logic                r_done;
    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS:0]   trial;
    logic                fits;

    // Restoring division: the dividend shifts out of r_quo one bit per cycle
    // while the quotient bits shift in behind it.
    assign trial = {r_rem[DEN_BITS-1:0], r_quo[NUM_BITS-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_count <= CNT_BITS'(NUM_BITS);
            end else if (r_count != '0) begin
                r_count <= r_count - CNT_BITS'(1);
                r_done  <= (r_count == CNT_BITS'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_count != '0) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[NUM_BITS-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    `FRET_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_start, r_count == '0)
    `FRET_ASSERT_IMP(a_rem_below_den, i_clk, i_rst_n, r_count != '0, r_rem < {1'b0, r_den})
    `FRET_ASSERT_IMP(a_done_after_last, i_clk, i_rst_n, o_done, $past(r_count) == CNT_BITS'(1))

endmodule

// ===== src/fret_ctrl.sv =====
`include "frame_rate_estimator_throttle_core_macros.svh"

module fret_ctrl #(
    parameter int STAMP_BITS = fret_pkg::DEF_STAMP_BITS,
    parameter int WAIT_BITS  = fret_pkg::DEF_WAIT_BITS,
    parameter int FRAC_BITS  = fret_pkg::DEF_FRAC_BITS,
    parameter int RATE_BITS  = FRAC_BITS + fret_pkg::RATE_INT_BITS,
    parameter int SUM_BITS   = RATE_BITS + fret_pkg::SUM_GUARD_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fret_in_if.sink                          i_in,
    input  logic [fret_pkg::TARGET_BITS-1:0] i_target,
    input  logic                             i_unlimited,
    output logic                             o_div_start,
    output logic [SUM_BITS-1:0]              o_div_num,
    output logic [RATE_BITS-1:0]             o_div_den,
    input  logic                             i_div_done,
    input  logic [SUM_BITS-1:0]              i_div_quot,
    output logic                             o_emit_valid,
    output logic [WAIT_BITS-1:0]             o_emit_wait,
    output logic [RATE_BITS-1:0]             o_emit_rate,
    input  logic                             i_emit_ready
);

    localparam int CMP_BITS = (RATE_BITS > fret_pkg::TARGET_BITS) ?
                              RATE_BITS : fret_pkg::TARGET_BITS;
    localparam int EXT_BITS = ((STAMP_BITS > RATE_BITS) ? STAMP_BITS : RATE_BITS) + 1;
    localparam logic [RATE_BITS-1:0] RATE_MAX =
        RATE_BITS'(fret_pkg::MS_PER_SEC) << FRAC_BITS;
    localparam logic [EXT_BITS-1:0] DEN_LIMIT = EXT_BITS'(1) << RATE_BITS;

    fret_pkg::t_state  r_state;
    fret_pkg::t_state  n_state;
    fret_pkg::t_action r_action;

    logic [STAMP_BITS-1:0] r_stamp;
    logic [STAMP_BITS-1:0] r_prev;
    logic [STAMP_BITS-1:0] r_diff;
    logic [RATE_BITS-1:0]  r_instant;
    logic [SUM_BITS-1:0]   r_acc;
    logic [RATE_BITS-1:0]  r_avg;
    logic [WAIT_BITS-1:0]  r_wait;
    logic [WAIT_BITS-1:0]  n_wait;
    logic                  r_seen;

    logic                  in_fire;
    logic                  emit_fire;
    logic [EXT_BITS-1:0]   diff_ext;
    logic                  too_big;
    logic [RATE_BITS-1:0]  interval_den;
    logic                  query_active;
    logic [CMP_BITS-1:0]   avg_cmp;
    logic [CMP_BITS-1:0]   tgt_cmp;
    logic                  query_out;
    logic                  query_emit;
    logic                  in_div_state;

    assign in_fire   = i_in.valid && i_in.ready;
    assign emit_fire = o_emit_valid && i_emit_ready;

    // An interval wider than the divisor gives an instant rate of zero,
    // since the dividend is always below 2^RATE_BITS.
    assign diff_ext     = EXT_BITS'(r_diff);
    assign too_big      = diff_ext >= DEN_LIMIT;
    assign interval_den = (r_diff == '0) ? RATE_BITS'(1) : diff_ext[RATE_BITS-1:0];

    assign query_active = r_seen && !i_unlimited;
    assign avg_cmp      = CMP_BITS'(r_avg);
    assign tgt_cmp      = CMP_BITS'(i_target);

    assign query_out    = o_emit_valid && (r_action == fret_pkg::ACT_QUERY);
    assign query_emit   = query_out && i_emit_ready;
    assign in_div_state = (r_state == fret_pkg::ST_DIV_RATE)
                          || (r_state == fret_pkg::ST_DIV_AVG);

    always_comb begin
        n_wait = r_wait;
        if ((avg_cmp < tgt_cmp) && (r_wait != '0)) begin
            n_wait = r_wait - WAIT_BITS'(1);
        end else if ((avg_cmp > tgt_cmp) && (r_wait != '1)) begin
            n_wait = r_wait + WAIT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fret_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fret_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = (fret_pkg::t_action'(i_in.action) == fret_pkg::ACT_TICK
                               && r_seen) ? fret_pkg::ST_INTERVAL : fret_pkg::ST_EMIT;
                end
            end
            fret_pkg::ST_INTERVAL: begin
                n_state = fret_pkg::ST_RATE_START;
            end
            fret_pkg::ST_RATE_START: begin
                n_state = too_big ? fret_pkg::ST_BLEND_OLD : fret_pkg::ST_DIV_RATE;
            end
            fret_pkg::ST_DIV_RATE: begin
                if (i_div_done) begin
                    n_state = fret_pkg::ST_BLEND_OLD;
                end
            end
            fret_pkg::ST_BLEND_OLD: begin
                n_state = fret_pkg::ST_BLEND_NEW;
            end
            fret_pkg::ST_BLEND_NEW: begin
                n_state = fret_pkg::ST_AVG_START;
            end
            fret_pkg::ST_AVG_START: begin
                n_state = fret_pkg::ST_DIV_AVG;
            end
            fret_pkg::ST_DIV_AVG: begin
                if (i_div_done) begin
                    n_state = fret_pkg::ST_EMIT;
                end
            end
            fret_pkg::ST_EMIT: begin
                if (i_emit_ready) begin
                    n_state = fret_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fret_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready   = (r_state == fret_pkg::ST_IDLE);
        o_div_start  = ((r_state == fret_pkg::ST_RATE_START) && !too_big)
                       || (r_state == fret_pkg::ST_AVG_START);
        o_div_num    = SUM_BITS'(RATE_MAX);
        o_div_den    = interval_den;
        if (r_state == fret_pkg::ST_AVG_START) begin
            o_div_num = r_acc;
            o_div_den = RATE_BITS'(fret_pkg::BLEND_DEN);
        end
        o_emit_valid = (r_state == fret_pkg::ST_EMIT);
        o_emit_rate  = r_avg;
        o_emit_wait  = r_wait;
        if (r_action == fret_pkg::ACT_QUERY) begin
            o_emit_wait = query_active ? n_wait : '0;
        end
    end

    // Architectural state of the estimator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_wait <= '0;
            r_avg  <= '0;
            r_prev <= '0;
        end else begin
            if (emit_fire) begin
                if (r_action == fret_pkg::ACT_QUERY) begin
                    if (query_active) begin
                        r_wait <= n_wait;
                    end
                end else if (!r_seen) begin
                    r_seen <= 1'b1;
                    r_prev <= r_stamp;
                end
            end
            if ((r_state == fret_pkg::ST_DIV_AVG) && i_div_done) begin
                r_avg  <= i_div_quot[RATE_BITS-1:0];
                r_prev <= r_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= fret_pkg::t_action'(i_in.action);
            r_stamp  <= i_in.timestamp_ms;
        end
        if (r_state == fret_pkg::ST_INTERVAL) begin
            r_diff <= r_stamp - r_prev;
        end
        if ((r_state == fret_pkg::ST_RATE_START) && too_big) begin
            r_instant <= '0;
        end
        if ((r_state == fret_pkg::ST_DIV_RATE) && i_div_done) begin
            r_instant <= i_div_quot[RATE_BITS-1:0];
        end
        if (r_state == fret_pkg::ST_BLEND_OLD) begin
            r_acc <= SUM_BITS'(r_avg) * SUM_BITS'(fret_pkg::BLEND_OLD)
                     + SUM_BITS'(fret_pkg::BLEND_ROUND);
        end
        if (r_state == fret_pkg::ST_BLEND_NEW) begin
            r_acc <= r_acc + SUM_BITS'(r_instant) * SUM_BITS'(fret_pkg::BLEND_NEW);
        end
    end

    `FRET_ASSERT_IMP(a_avg_in_range, i_clk, i_rst_n, 1'b1, r_avg <= RATE_MAX)
    `FRET_ASSERT_NXT(a_wait_only_on_query, i_clk, i_rst_n, !query_emit, $stable(r_wait))
    `FRET_ASSERT_IMP(a_div_done_expected, i_clk, i_rst_n, i_div_done, in_div_state)
    `FRET_ASSERT_IMP(a_unlimited_zero, i_clk, i_rst_n, query_out && i_unlimited, o_emit_wait == '0)

endmodule
